>>> rtl/crr_pkg.sv
package crr_pkg;

    localparam int STAGES_DEF     = 8;
    localparam int ENTRIES_DEF    = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam int FIELD_BITS = 32;
    localparam int STAGE_BITS = 3;
    localparam int SLOT_BITS  = 6;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_XLATE = 1'b1;

    // control half of a transaction moving down the chain
    typedef struct packed {
        logic                  valid;
        logic                  op;
        logic [STAGE_BITS-1:0] stage;
        logic [SLOT_BITS-1:0]  slot;
        logic                  entry_valid;
        logic                  new_batch;
        logic                  hit;
    } ctl_t;

endpackage

>>> rtl/crr_cell.sv
module crr_cell #(
    parameter int VALUE_BITS = crr_pkg::VALUE_BITS_DEF,
    parameter int CELL_STAGE = 0,
    parameter int CELL_SLOT  = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  crr_pkg::ctl_t         in_ctl,
    input  logic [VALUE_BITS-1:0] in_value,
    input  logic [VALUE_BITS-1:0] in_dest,
    input  logic [VALUE_BITS-1:0] in_src,
    input  logic [VALUE_BITS-1:0] in_len,
    output crr_pkg::ctl_t         out_ctl,
    output logic [VALUE_BITS-1:0] out_value,
    output logic [VALUE_BITS-1:0] out_dest,
    output logic [VALUE_BITS-1:0] out_src,
    output logic [VALUE_BITS-1:0] out_len
);

    logic                  ent_valid_reg;
    logic [VALUE_BITS-1:0] dest_reg;
    logic [VALUE_BITS-1:0] src_reg;
    logic [VALUE_BITS-1:0] len_reg;

    crr_pkg::ctl_t         ctl_reg;
    crr_pkg::ctl_t         ctl_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic [VALUE_BITS-1:0] pdest_reg;
    logic [VALUE_BITS-1:0] psrc_reg;
    logic [VALUE_BITS-1:0] plen_reg;

    logic                  hit_in;
    logic [VALUE_BITS-1:0] diff;
    logic                  in_range;
    logic                  is_write;
    logic                  is_xlate;
    logic                  addr_hit;
    logic                  take;
    logic                  ent_write;

    always_comb
    begin
        hit_in   = (CELL_SLOT == 0) ? 1'b0 : in_ctl.hit;
        diff     = in_value - src_reg;
        in_range = ent_valid_reg && (in_value >= src_reg) && (diff < len_reg);
        is_write = in_ctl.valid && (in_ctl.op == crr_pkg::OP_WRITE);
        is_xlate = in_ctl.valid && (in_ctl.op == crr_pkg::OP_XLATE);
        addr_hit = (int'(in_ctl.stage) == CELL_STAGE) && (int'(in_ctl.slot) == CELL_SLOT);
        take     = is_xlate && !hit_in && in_range;
        ent_write = advance && is_write && addr_hit;

        ctl_next     = in_ctl;
        ctl_next.hit = hit_in || take;
        value_next   = take ? (dest_reg + diff) : in_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= 1'b0;
            ctl_reg       <= '0;
        end
        else
        begin
            if (ent_write)
            begin
                ent_valid_reg <= in_ctl.entry_valid;
            end
            if (advance)
            begin
                ctl_reg <= ctl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ent_write)
        begin
            dest_reg <= in_dest;
            src_reg  <= in_src;
            len_reg  <= in_len;
        end
        if (advance)
        begin
            value_reg <= value_next;
            pdest_reg <= in_dest;
            psrc_reg  <= in_src;
            plen_reg  <= in_len;
        end
    end

    assign out_ctl   = ctl_reg;
    assign out_value = value_reg;
    assign out_dest  = pdest_reg;
    assign out_src   = psrc_reg;
    assign out_len   = plen_reg;

endmodule

>>> rtl/crr_out.sv
module crr_out #(
    parameter int VALUE_BITS = crr_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  crr_pkg::ctl_t                 last_ctl,
    input  logic [VALUE_BITS-1:0]         last_value,
    input  logic                          rsp_ready,
    output logic                          rsp_valid,
    output logic [crr_pkg::FIELD_BITS-1:0] location,
    output logic [crr_pkg::FIELD_BITS-1:0] batch_min,
    output logic                          advance
);

    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    logic [VALUE_BITS-1:0] loc_reg;
    logic [VALUE_BITS-1:0] min_reg;
    logic [VALUE_BITS-1:0] min_next;
    logic                  is_xlate;
    logic                  take;

    always_comb
    begin
        is_xlate = last_ctl.valid && (last_ctl.op == crr_pkg::OP_XLATE);
        advance  = !rsp_valid_reg || rsp_ready || !is_xlate;
        take     = advance && is_xlate;
        if (take)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && !rsp_ready;
        end
        min_next = (last_ctl.new_batch || (last_value < min_reg)) ? last_value : min_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            min_reg       <= '1;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (take)
            begin
                min_reg <= min_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            loc_reg <= last_value;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign location  = crr_pkg::FIELD_BITS'(loc_reg);
    assign batch_min = crr_pkg::FIELD_BITS'(min_reg);

endmodule

>>> rtl/chained_range_remap.sv
// Range remap chain: one cell per table entry, STAGES*ENTRIES cells in a row,
// stage-major. Every transaction walks the row one cell per cycle while the row
// is not stalled; a write lands in the cell of its stage and slot, a translate
// is remapped by the first valid matching cell of each stage. Accepts one
// transaction per cycle while not stalled; a result passes one register per
// cell, the first loading on the accepting edge, then the output register
// taking the hand-off from the last cell. The whole row stalls only while the
// output register holds an untaken result and a translate waits behind it.
// Table contents need no clearing after reset; only the per-cell valid flags
// are reset. Writes to an absent stage or slot are dropped.
module chained_range_remap #(
    parameter int STAGES     = crr_pkg::STAGES_DEF,
    parameter int ENTRIES    = crr_pkg::ENTRIES_DEF,
    parameter int VALUE_BITS = crr_pkg::VALUE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  logic                             op,
    input  logic [crr_pkg::STAGE_BITS-1:0]   stage,
    input  logic [crr_pkg::SLOT_BITS-1:0]    slot,
    input  logic                             entry_valid,
    input  logic [crr_pkg::FIELD_BITS-1:0]   dest_start,
    input  logic [crr_pkg::FIELD_BITS-1:0]   src_start,
    input  logic [crr_pkg::FIELD_BITS-1:0]   span_len,
    input  logic [crr_pkg::FIELD_BITS-1:0]   value,
    input  logic                             new_batch,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output logic [crr_pkg::FIELD_BITS-1:0]   location,
    output logic [crr_pkg::FIELD_BITS-1:0]   batch_min
);

    localparam int CELLS = STAGES * ENTRIES;

    crr_pkg::ctl_t         ctl   [CELLS+1];
    logic [VALUE_BITS-1:0] val   [CELLS+1];
    logic [VALUE_BITS-1:0] dst   [CELLS+1];
    logic [VALUE_BITS-1:0] src   [CELLS+1];
    logic [VALUE_BITS-1:0] len   [CELLS+1];
    logic                  advance;

    always_comb
    begin
        ctl[0].valid       = req_valid;
        ctl[0].op          = op;
        ctl[0].stage       = stage;
        ctl[0].slot        = slot;
        ctl[0].entry_valid = entry_valid;
        ctl[0].new_batch   = new_batch;
        ctl[0].hit         = 1'b0;
        val[0]             = VALUE_BITS'(value);
        dst[0]             = VALUE_BITS'(dest_start);
        src[0]             = VALUE_BITS'(src_start);
        len[0]             = VALUE_BITS'(span_len);
    end

    assign req_ready = advance;

    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        crr_cell #(
            .VALUE_BITS (VALUE_BITS),
            .CELL_STAGE (k / ENTRIES),
            .CELL_SLOT  (k % ENTRIES)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_ctl    (ctl[k]),
            .in_value  (val[k]),
            .in_dest   (dst[k]),
            .in_src    (src[k]),
            .in_len    (len[k]),
            .out_ctl   (ctl[k+1]),
            .out_value (val[k+1]),
            .out_dest  (dst[k+1]),
            .out_src   (src[k+1]),
            .out_len   (len[k+1])
        );
    end

    crr_out #(
        .VALUE_BITS (VALUE_BITS)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .last_ctl   (ctl[CELLS]),
        .last_value (val[CELLS]),
        .rsp_ready  (rsp_ready),
        .rsp_valid  (rsp_valid),
        .location   (location),
        .batch_min  (batch_min),
        .advance    (advance)
    );

endmodule

>>> rtl/crr_checker.sv
module crr_checker #(
    parameter int VALUE_BITS = crr_pkg::VALUE_BITS_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [crr_pkg::FIELD_BITS-1:0] location,
    input logic [crr_pkg::FIELD_BITS-1:0] batch_min
);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(location) && $stable(batch_min))
        else $error("stalled result changed");

    // running minimum includes the current result
    a_min_le_loc: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (VALUE_BITS > crr_pkg::FIELD_BITS) || (batch_min <= location))
        else $error("batch_min above location");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !rsp_valid)
        else $error("result valid after reset");

    // request side is open whenever the output register is free
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request blocked with empty output");

endmodule

bind chained_range_remap crr_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_crr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .location  (location),
    .batch_min (batch_min)
);

>>> tb/chained_range_remap_checker.sv
module chained_range_remap_checker #(
    parameter int STAGES     = crr_pkg::STAGES_DEF,
    parameter int ENTRIES    = crr_pkg::ENTRIES_DEF,
    parameter int VALUE_BITS = crr_pkg::VALUE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic                           req_ready,
    input  logic                           op,
    input  logic [crr_pkg::STAGE_BITS-1:0] stage,
    input  logic [crr_pkg::SLOT_BITS-1:0]  slot,
    input  logic                           entry_valid,
    input  logic [crr_pkg::FIELD_BITS-1:0] dest_start,
    input  logic [crr_pkg::FIELD_BITS-1:0] src_start,
    input  logic [crr_pkg::FIELD_BITS-1:0] span_len,
    input  logic [crr_pkg::FIELD_BITS-1:0] value,
    input  logic                           new_batch,
    input  logic                           rsp_valid,
    input  logic                           rsp_ready,
    input  logic [crr_pkg::FIELD_BITS-1:0] location,
    input  logic [crr_pkg::FIELD_BITS-1:0] batch_min,
    output int                             mismatches,
    output int                             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS = STAGES * ENTRIES;

    typedef logic [VALUE_BITS-1:0] word_t;

    typedef struct packed {
        logic [crr_pkg::FIELD_BITS-1:0] location;
        logic [crr_pkg::FIELD_BITS-1:0] batch_min;
    } remap_result_t;

    word_t ent_dest [CELLS];
    word_t ent_src  [CELLS];
    word_t ent_len  [CELLS];
    bit    ent_on   [CELLS];
    word_t run_min = '1;
    int    fail_count;

    remap_result_t predicted_locs [$];

    // lowest matching slot wins: scan high to low and keep the last hit
    function automatic word_t remap_through_chain(word_t v);
        word_t cur;
        word_t nxt;
        int    idx;
        cur = v;
        for (int s = 0; s < STAGES; s++)
        begin
            nxt = cur;
            for (int e = ENTRIES - 1; e >= 0; e--)
            begin
                idx = s * ENTRIES + e;
                if (ent_on[idx] && cur >= ent_src[idx] && (cur - ent_src[idx]) < ent_len[idx])
                    nxt = ent_dest[idx] + (cur - ent_src[idx]);
            end
            cur = nxt;
        end
        return cur;
    endfunction

    always @(posedge clk)
    begin
        word_t         loc;
        remap_result_t want;
        int            idx;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (predicted_locs.size() == 0)
                begin
                    $display("%0t: unexpected transaction: location %h batch_min %h",
                             $time, location, batch_min);
                    fail_count++;
                end
                else
                begin
                    want = predicted_locs.pop_front();
                    if (location !== want.location)
                    begin
                        $display("%0t: location expected %h actual %h",
                                 $time, want.location, location);
                        fail_count++;
                    end
                    if (batch_min !== want.batch_min)
                    begin
                        $display("%0t: batch_min expected %h actual %h",
                                 $time, want.batch_min, batch_min);
                        fail_count++;
                    end
                end
            end

            if (req_valid && req_ready)
            begin
                if (op == crr_pkg::OP_WRITE)
                begin
                    if (stage < STAGES && slot < ENTRIES)
                    begin
                        idx = stage * ENTRIES + slot;
                        ent_on[idx]   = entry_valid;
                        ent_dest[idx] = word_t'(dest_start);
                        ent_src[idx]  = word_t'(src_start);
                        ent_len[idx]  = word_t'(span_len);
                    end
                end
                else
                begin
                    loc = remap_through_chain(word_t'(value));
                    if (new_batch || loc < run_min)
                        run_min = loc;
                    want.location  = crr_pkg::FIELD_BITS'(loc);
                    want.batch_min = crr_pkg::FIELD_BITS'(run_min);
                    predicted_locs = {predicted_locs, want};
                end
            end

            mismatches  <= fail_count;
            outstanding <= predicted_locs.size();
        end
    end

endmodule

>>> tb/chained_range_remap_test.sv
module chained_range_remap_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 7;
    localparam int RANDOM_ITEMS    = 550;
    localparam int LONG_HOLD       = 1200;
    localparam int LONG_HOLD_AFTER = 150;
    localparam int DRAIN_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int SPAN_KEEP       = 64;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           req_valid;
    logic                           req_ready;
    logic                           op;
    logic [crr_pkg::STAGE_BITS-1:0] stage;
    logic [crr_pkg::SLOT_BITS-1:0]  slot;
    logic                           entry_valid;
    logic [crr_pkg::FIELD_BITS-1:0] dest_start;
    logic [crr_pkg::FIELD_BITS-1:0] src_start;
    logic [crr_pkg::FIELD_BITS-1:0] span_len;
    logic [crr_pkg::FIELD_BITS-1:0] value;
    logic                           new_batch;
    logic                           rsp_valid;
    logic                           rsp_ready;
    logic [crr_pkg::FIELD_BITS-1:0] location;
    logic [crr_pkg::FIELD_BITS-1:0] batch_min;

    int mismatches;
    int outstanding;
    int quiet_cycles;

    bit req_burst;
    bit rsp_burst;

    // last SPAN_KEEP valid nonzero-length ranges loaded, used to aim translate values at loaded entries
    logic [crr_pkg::FIELD_BITS-1:0] span_lo  [$];
    logic [crr_pkg::FIELD_BITS-1:0] span_cnt [$];

    always #(CLK_PERIOD / 2) clk = ~clk;

    chained_range_remap u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .op          (op),
        .stage       (stage),
        .slot        (slot),
        .entry_valid (entry_valid),
        .dest_start  (dest_start),
        .src_start   (src_start),
        .span_len    (span_len),
        .value       (value),
        .new_batch   (new_batch),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .location    (location),
        .batch_min   (batch_min)
    );

    chained_range_remap_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .op          (op),
        .stage       (stage),
        .slot        (slot),
        .entry_valid (entry_valid),
        .dest_start  (dest_start),
        .src_start   (src_start),
        .span_len    (span_len),
        .value       (value),
        .new_batch   (new_batch),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .location    (location),
        .batch_min   (batch_min),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic int idle_cycles(bit burst);
        return burst ? 0 : $urandom_range(0, 15);
    endfunction

    task automatic send_item(input logic t_op, input logic [crr_pkg::STAGE_BITS-1:0] t_stage,
                             input logic [crr_pkg::SLOT_BITS-1:0] t_slot, input logic t_ev,
                             input logic [crr_pkg::FIELD_BITS-1:0] t_dest,
                             input logic [crr_pkg::FIELD_BITS-1:0] t_src,
                             input logic [crr_pkg::FIELD_BITS-1:0] t_len,
                             input logic [crr_pkg::FIELD_BITS-1:0] t_value, input logic t_nb);
        int gap;
        gap = idle_cycles(req_burst);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid   <= 1'b1;
        op          <= t_op;
        stage       <= t_stage;
        slot        <= t_slot;
        entry_valid <= t_ev;
        dest_start  <= t_dest;
        src_start   <= t_src;
        span_len    <= t_len;
        value       <= t_value;
        new_batch   <= t_nb;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    // new_batch and value are noise on a write
    task automatic put_entry(input logic [crr_pkg::STAGE_BITS-1:0] t_stage,
                             input logic [crr_pkg::SLOT_BITS-1:0] t_slot, input logic t_ev,
                             input logic [crr_pkg::FIELD_BITS-1:0] t_dest,
                             input logic [crr_pkg::FIELD_BITS-1:0] t_src,
                             input logic [crr_pkg::FIELD_BITS-1:0] t_len);
        send_item(crr_pkg::OP_WRITE, t_stage, t_slot, t_ev, t_dest, t_src, t_len, $urandom,
                  1'($urandom_range(0, 1)));
        if (t_ev && t_len != '0)
        begin
            span_lo  = {span_lo, t_src};
            span_cnt = {span_cnt, t_len};
            if (span_lo.size() > SPAN_KEEP)
            begin
                void'(span_lo.pop_front());
                void'(span_cnt.pop_front());
            end
        end
    endtask

    task automatic xlate(input logic [crr_pkg::FIELD_BITS-1:0] t_value, input logic t_nb);
        send_item(crr_pkg::OP_XLATE, crr_pkg::STAGE_BITS'($urandom_range(0, 7)),
                  crr_pkg::SLOT_BITS'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                  $urandom, $urandom, $urandom, t_value, t_nb);
    endtask

    initial
    begin
        logic [crr_pkg::STAGE_BITS-1:0] w_stage;
        logic [crr_pkg::SLOT_BITS-1:0]  w_slot;
        logic                           w_ev;
        logic [crr_pkg::FIELD_BITS-1:0] w_dest;
        logic [crr_pkg::FIELD_BITS-1:0] w_src;
        logic [crr_pkg::FIELD_BITS-1:0] w_len;
        logic [crr_pkg::FIELD_BITS-1:0] v;
        int                             kind;
        int                             k;

        rst_n       <= 1'b0;
        req_valid   <= 1'b0;
        op          <= crr_pkg::OP_WRITE;
        stage       <= '0;
        slot        <= '0;
        entry_valid <= 1'b0;
        dest_start  <= '0;
        src_start   <= '0;
        span_len    <= '0;
        value       <= '0;
        new_batch   <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty tables: values pass unchanged
        xlate(32'h0000_0000, 1'b1);
        xlate(32'hFFFF_FFFF, 1'b0);
        // overlapping entries, lower slot wins
        put_entry(3'd0, 6'd1, 1'b1, 32'd1000, 32'd100, 32'd50);
        put_entry(3'd0, 6'd0, 1'b1, 32'd5000, 32'd120, 32'd10);
        xlate(32'd125, 1'b1);
        xlate(32'd110, 1'b0);
        xlate(32'd149, 1'b0);
        xlate(32'd150, 1'b0);
        xlate(32'd99, 1'b0);
        // zero length matches nothing
        put_entry(3'd1, 6'd0, 1'b1, 32'd7, 32'd1010, 32'd0);
        xlate(32'd110, 1'b0);
        // range running past the top, destination wraps
        put_entry(3'd7, 6'd63, 1'b1, 32'hFFFF_FFF0, 32'hFFFF_FF00, 32'hFFFF_FFFF);
        xlate(32'hFFFF_FFFF, 1'b1);
        xlate(32'hFFFF_FF00, 1'b0);
        xlate(32'hFFFF_FEFF, 1'b0);
        // invalidated entry keeps its fields but stops matching
        put_entry(3'd0, 6'd0, 1'b0, 32'd5000, 32'd120, 32'd10);
        xlate(32'd125, 1'b0);
        put_entry(3'd2, 6'd5, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        xlate(32'h0000_0000, 1'b1);
        xlate(32'h0000_1234, 1'b0);
        put_entry(3'd2, 6'd5, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        xlate(32'h0000_1234, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 39) == 0)
                req_burst = !req_burst;
            if ($urandom_range(0, 9) < 3)
            begin
                w_stage = crr_pkg::STAGE_BITS'($urandom_range(0, 7));
                w_slot  = ($urandom_range(0, 9) < 6) ? crr_pkg::SLOT_BITS'($urandom_range(0, 7))
                                                     : crr_pkg::SLOT_BITS'($urandom_range(0, 63));
                w_ev    = ($urandom_range(0, 4) != 0);
                kind    = $urandom_range(0, 9);
                if (kind < 7)
                begin
                    w_src  = $urandom_range(0, 4095);
                    w_len  = $urandom_range(0, 1023);
                    w_dest = $urandom_range(0, 4095);
                end
                else if (kind < 9)
                begin
                    w_src  = $urandom;
                    w_len  = $urandom;
                    w_dest = $urandom;
                end
                else
                begin
                    w_src  = 32'hFFFF_F000 | $urandom_range(0, 4095);
                    w_len  = $urandom;
                    w_dest = $urandom;
                end
                put_entry(w_stage, w_slot, w_ev, w_dest, w_src, w_len);
            end
            else
            begin
                kind = $urandom_range(0, 19);
                k    = (span_lo.size() > 0) ? $urandom_range(0, span_lo.size() - 1) : -1;
                if (kind < 8)
                    v = $urandom_range(0, 4095);
                else if (kind < 15 && k >= 0)
                    v = span_lo[k] + ($urandom % span_cnt[k]);
                else if (kind == 18 && k >= 0)
                    v = span_lo[k] + span_cnt[k];
                else if (kind == 19)
                    v = $urandom_range(0, 1) ? '1 : '0;
                else
                    v = $urandom;
                xlate(v, $urandom_range(0, 9) == 0);
            end
        end
        req_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("chained_range_remap_test: clean");
        else
            $display("chained_range_remap_test: errors");
        $finish;
    end

    initial
    begin
        int hold;
        int taken;
        bit held_long;
        rsp_ready <= 1'b0;
        taken     = 0;
        held_long = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (!held_long && taken == LONG_HOLD_AFTER)
            begin
                hold      = LONG_HOLD;
                held_long = 1'b1;
            end
            else
                hold = idle_cycles(rsp_burst);
            if ($urandom_range(0, 31) == 0)
                rsp_burst = !rsp_burst;
            if (hold > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
            taken++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("chained_range_remap_test: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

>>> filelist.f
rtl/crr_pkg.sv
rtl/crr_cell.sv
rtl/crr_out.sv
rtl/chained_range_remap.sv
rtl/crr_checker.sv
tb/chained_range_remap_checker.sv
tb/chained_range_remap_test.sv
